### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CVP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Expression holds at every sampled edge out of reset.
`define CVP_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("%m: assertion failed");

`endif

### hdl/cvp_pkg.sv
package cvp_pkg;

	localparam int TIME_W    = 16;
	localparam int DUR_W     = 16;
	localparam int VEL_W     = 32;
	localparam int IDX_W     = 3;
	// T^3 width and scaled numerator width
	localparam int D_W       = 3 * DUR_W;
	localparam int NUM_W     = 104;
	// quotient bits kept; larger quotients saturate anyway
	localparam int DIV_STEPS = 35;
	localparam int REM_W     = D_W;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_V0  = 3'd0,
		REG_V1  = 3'd1,
		REG_A0  = 3'd2,
		REG_A1  = 3'd3,
		REG_DUR = 3'd4,
		REG_UP  = 3'd5
	} reg_idx_t;

	// per-beat control that rides next to the divider data
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero;
		logic big;
	} side_t;

endpackage

### hdl/cubic_velocity_profile.sv
// Channel  | Ports                                    | Handshake
// ---------+------------------------------------------+----------------------------
// input    | time_tick                                | start high, busy low
// config   | wr_index, wr_data                        | wr_en high, no wait
// result   | velocity, status                         | done strobe, one cycle
//
// One beat enters per cycle; busy stays low.
// The pipeline has 7 multiply/add stages that build T^3*c(t), then
// a divider entry stage and 35 bit-per-stage divide stages by T^3,
// and two output stages.
// Reset zeroes v0, v1, a0 and a1, sets the duration to 1 and the count-up flag, and clears all stage valid bits.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module cubic_velocity_profile (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [cvp_pkg::TIME_W-1:0]        time_tick,
	input  logic                              wr_en,
	input  logic [cvp_pkg::IDX_W-1:0]         wr_index,
	input  logic [cvp_pkg::VEL_W-1:0]         wr_data,
	output logic                              done,
	output logic signed [cvp_pkg::VEL_W-1:0]  velocity,
	output logic [1:0]                        status
);

	localparam int NW  = cvp_pkg::NUM_W;
	localparam int DW  = cvp_pkg::D_W;
	localparam int S   = cvp_pkg::DIV_STEPS;
	localparam int LAT = 45;

	// config registers
	logic signed [31:0] v0_q, v1_q, a0_q, a1_q;
	logic [15:0]        dur_q;
	logic               up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q  <= '0;
			v1_q  <= '0;
			a0_q  <= '0;
			a1_q  <= '0;
			dur_q <= 16'd1;
			up_q  <= 1'b1;
		end else if (wr_en) begin
			case (cvp_pkg::reg_idx_t'(wr_index))
				cvp_pkg::REG_V0:  v0_q  <= $signed(wr_data);
				cvp_pkg::REG_V1:  v1_q  <= $signed(wr_data);
				cvp_pkg::REG_A0:  a0_q  <= $signed(wr_data);
				cvp_pkg::REG_A1:  a1_q  <= $signed(wr_data);
				cvp_pkg::REG_DUR: dur_q <= wr_data[15:0];
				cvp_pkg::REG_UP:  up_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic signed [16:0] t_ext;
	logic signed [16:0] dur_ext;
	logic signed [34:0] dv;
	assign t_ext   = $signed({1'b0, time_tick});
	assign dur_ext = $signed({1'b0, dur_q});
	assign dv      = 35'(v1_q) - 35'(v0_q);

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <=
				{accept, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6};
		end
	end

	// S1: t^2, T^2, P = v0 + a0*t, Q = 3(v1-v0) + (a0+a1)*t, R = 2(v0-v1)*t, K = -(2*a0+a1)
	logic [31:0]        t2_s1, tsq_s1;
	logic signed [49:0] p_s1;
	logic signed [50:0] q_s1, r_s1;
	logic signed [34:0] k_s1;

	always_ff @(posedge clk) begin
		t2_s1  <= 32'(time_tick) * 32'(time_tick);
		tsq_s1 <= 32'(dur_q) * 32'(dur_q);
		p_s1   <= 50'(v0_q) + 50'(49'(a0_q) * 49'(t_ext));
		q_s1   <= (51'(dv) <<< 1) + 51'(dv)
			+ 51'(50'(33'(a0_q) + 33'(a1_q)) * 50'(t_ext));
		r_s1   <= (51'(-dv) * 51'(t_ext)) <<< 1;
		k_s1   <= -((35'(a0_q) <<< 1) + 35'(a1_q));
	end

	// S2: T^3, T*Q, K*T^2
	logic [DW-1:0]      d_s2;
	logic signed [67:0] tq_s2, kt_s2;
	logic signed [50:0] r_s2;
	logic signed [49:0] p_s2;
	logic [31:0]        t2_s2;

	always_ff @(posedge clk) begin
		d_s2  <= DW'(tsq_s1) * DW'(dur_q);
		tq_s2 <= 68'(dur_ext) * 68'(q_s1);
		kt_s2 <= 68'(k_s1) * 68'($signed({1'b0, tsq_s1}));
		r_s2  <= r_s1;
		p_s2  <= p_s1;
		t2_s2 <= t2_s1;
	end

	// S3: X = T*Q + K*T^2 + R
	logic signed [69:0] x_s3;
	logic [DW-1:0]      d_s3;
	logic signed [49:0] p_s3;
	logic [31:0]        t2_s3;

	always_ff @(posedge clk) begin
		x_s3  <= 70'(tq_s2) + 70'(kt_s2) + 70'(r_s2);
		d_s3  <= d_s2;
		p_s3  <= p_s2;
		t2_s3 <= t2_s2;
	end

	// S4: partial products of T^3*P and t^2*X
	logic [72:0]        m0_s4;
	logic signed [73:0] m1_s4;
	logic [54:0]        n0_s4, n1_s4;
	logic signed [56:0] n2_s4;
	logic [DW-1:0]      d_s4;

	always_ff @(posedge clk) begin
		m0_s4 <= 73'(d_s3) * 73'(p_s3[24:0]);
		m1_s4 <= 74'($signed({1'b0, d_s3})) * 74'($signed(p_s3[49:25]));
		n0_s4 <= 55'(t2_s3) * 55'(x_s3[22:0]);
		n1_s4 <= 55'(t2_s3) * 55'(x_s3[45:23]);
		n2_s4 <= 57'($signed({1'b0, t2_s3})) * 57'($signed(x_s3[69:46]));
		d_s4  <= d_s3;
	end

	// S5: partial sums
	logic [NW-1:0] a_s5, b_s5;
	logic [DW-1:0] d_s5;

	always_ff @(posedge clk) begin
		a_s5 <= (NW'(m1_s4) << 25) + NW'(m0_s4);
		b_s5 <= (NW'(n2_s4) << 46) + (NW'(n1_s4) << 23) + NW'(n0_s4);
		d_s5 <= d_s4;
	end

	// S6: N = T^3 * c(t)
	logic [NW-1:0] n_s6;
	logic [DW-1:0] d_s6;

	always_ff @(posedge clk) begin
		n_s6 <= a_s5 + b_s5;
		d_s6 <= d_s5;
	end

	// S7: |N| + floor(T^3/2), so the floor divide rounds half away from zero
	logic [NW-1:0]  num_s7;
	logic [DW-1:0]  d_s7;
	logic           neg_s7;
	logic [NW-1:0]  half;
	assign half = NW'(d_s6 >> 1);

	always_ff @(posedge clk) begin
		num_s7 <= n_s6[NW-1] ? (~n_s6 + half + NW'(1)) : (n_s6 + half);
		d_s7   <= d_s6;
		neg_s7 <= n_s6[NW-1];
	end

	cvp_pkg::side_t side_in, side_dv;
	logic [S-1:0]   quot;

	always_comb begin
		side_in       = '0;
		side_in.valid = vld_s7;
		side_in.neg   = neg_s7;
		side_in.zero  = (d_s7 == '0);
	end

	cvp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_in),
		.num      (num_s7),
		.den      (d_s7),
		.side_out (side_dv),
		.quot     (quot)
	);

	// F1: apply sign, then count-down form
	logic signed [35:0] c_val;
	logic signed [36:0] res_f1;
	cvp_pkg::side_t     side_f1;
	assign c_val = side_dv.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_f1 <= '0;
		end else begin
			side_f1 <= side_dv;
		end
	end

	always_ff @(posedge clk) begin
		res_f1 <= up_q ? 37'(c_val) : (37'(v1_q) - 37'(c_val));
	end

	// F2: saturate and drive the result
	logic fits;
	logic hi_sat;
	assign fits   = (res_f1[36:31] == '0) || (res_f1[36:31] == '1);
	assign hi_sat = side_f1.big ? (side_f1.neg ^ up_q) : !res_f1[36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_f1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (side_f1.zero) begin
			velocity <= '0;
			status   <= cvp_pkg::ST_ZERO;
		end else if (side_f1.big || !fits) begin
			velocity <= hi_sat ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			status   <= cvp_pkg::ST_SAT;
		end else begin
			velocity <= res_f1[31:0];
			status   <= cvp_pkg::ST_OK;
		end
	end

	// result beat flags for the checks below
	logic zero_beat, sat_beat, at_bound;
	assign zero_beat = done && status == cvp_pkg::ST_ZERO;
	assign sat_beat  = done && status == cvp_pkg::ST_SAT;
	assign at_bound  = velocity == 32'sh7FFF_FFFF || velocity == 32'sh8000_0000;

	// every result traces back to an accepted beat a fixed latency earlier
	`CVP_ASSERT_IMP(a_done_lat, clk, arst_n, done, $past(accept, LAT))
	// zero duration always reports a zero velocity
	`CVP_ASSERT_IMP(a_zero_val, clk, arst_n, zero_beat, velocity == '0)
	// saturation lands on a bound
	`CVP_ASSERT_IMP(a_sat_bound, clk, arst_n, sat_beat, at_bound)

endmodule

### hdl/cvp_div.sv
`include "assert_macros.svh"

// Pipelined restoring divider, one quotient bit per stage.
module cvp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cvp_pkg::side_t               side_in,
	input  logic [cvp_pkg::NUM_W-1:0]    num,
	input  logic [cvp_pkg::D_W-1:0]      den,
	output cvp_pkg::side_t               side_out,
	output logic [cvp_pkg::DIV_STEPS-1:0] quot
);

	localparam int S  = cvp_pkg::DIV_STEPS;
	localparam int RW = cvp_pkg::REM_W;
	localparam int DW = cvp_pkg::D_W;
	localparam int NW = cvp_pkg::NUM_W;

	cvp_pkg::side_t  side_s [0:S];
	logic [RW-1:0]   rem_s  [0:S];
	logic [S-1:0]    lo_s   [0:S];
	logic [DW-1:0]   den_s  [0:S];

	// entry stage: flag quotients that cannot fit, seed remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else begin
			side_s[0] <= {side_in.valid, side_in.neg, side_in.zero,
				(num[NW-1:S] >= (NW-S)'(den))};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num[S+RW-1:S];
		lo_s[0]  <= num[S-1:0];
		den_s[0] <= den;
	end

	// one shift-compare-subtract per stage
	for (genvar k = 0; k < S; k++) begin : g_step
		logic [RW:0] r2;
		logic        ge;

		always_comb begin
			r2 = {rem_s[k], lo_s[k][S-1]};
			ge = r2 >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else begin
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? RW'(r2 - {1'b0, den_s[k]}) : RW'(r2);
			lo_s[k+1]  <= {lo_s[k][S-2:0], ge};
			den_s[k+1] <= den_s[k];
		end
	end

	assign side_out = side_s[S];
	assign quot     = lo_s[S];

	// beats whose quotient fits in the kept bits
	logic fit_chk;
	assign fit_chk = side_s[S].valid && !side_s[S].big && !side_s[S].zero;

	// a quotient that fits leaves a remainder below the divisor
	`CVP_ASSERT_IMP(a_rem_lt_den, clk, arst_n, fit_chk, rem_s[S] < den_s[S])

endmodule

### verif/tb_cubic_velocity_profile.sv
`timescale 1ns / 1ps

module tb_cubic_velocity_profile;

	localparam int             WATCHDOG_LIMIT = 5000;
	localparam int             DRAIN_CYCLES   = 60;
	localparam logic [cvp_pkg::IDX_W-1:0] REG_UNUSED6 = 3'd6;
	localparam logic [cvp_pkg::IDX_W-1:0] REG_UNUSED7 = 3'd7;
	localparam logic signed [159:0] VEL_MAX   = 160'sd2147483647;
	localparam logic signed [159:0] VEL_MIN   = -VEL_MAX - 160'sd1;

	typedef struct {
		logic [cvp_pkg::VEL_W-1:0] velocity;
		cvp_pkg::status_t          status;
	} velocity_beat_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [cvp_pkg::TIME_W-1:0]       time_tick = '0;
	logic                             wr_en = 1'b0;
	logic [cvp_pkg::IDX_W-1:0]        wr_index = '0;
	logic [cvp_pkg::VEL_W-1:0]        wr_data = '0;
	logic                             done;
	logic signed [cvp_pkg::VEL_W-1:0] velocity;
	logic [1:0]                       status;

	// shadow copy of the profile registers
	logic signed [31:0] prof_v0 = 0, prof_v1 = 0, prof_a0 = 0, prof_a1 = 0;
	logic [15:0]        prof_dur = 16'd1;
	logic               prof_up = 1'b1;

	velocity_beat_t expected_velocity_q[$];
	int             error_count = 0;
	int             quiet_cycles = 0;
	bit             idling_on = 1'b1;

	cubic_velocity_profile u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .time_tick(time_tick),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .velocity(velocity), .status(status)
	);

	always #5 clk = ~clk;

	// exact cubic: T^3*c(t), rounded divide, optional count-down, saturate
	function automatic velocity_beat_t cubic_velocity(input logic [cvp_pkg::TIME_W-1:0] t);
		velocity_beat_t     r;
		logic signed [159:0] v0, v1, a0, a1, tt, dd, num, d3, q;
		logic               neg;
		v0 = prof_v0;
		v1 = prof_v1;
		a0 = prof_a0;
		a1 = prof_a1;
		tt = {144'd0, t};
		dd = {144'd0, prof_dur};
		if (prof_dur == 0) begin
			r.velocity = '0;
			r.status = cvp_pkg::ST_ZERO;
			return r;
		end
		num = v0*dd*dd*dd + a0*dd*dd*dd*tt + 3*(v1-v0)*dd*tt*tt
			- (2*a0+a1)*dd*dd*tt*tt + 2*(v0-v1)*tt*tt*tt + (a0+a1)*dd*tt*tt*tt;
		d3 = dd*dd*dd;
		neg = num < 0;
		if (neg) num = -num;
		q = (num + (d3 >>> 1)) / d3;
		if (neg) q = -q;
		if (!prof_up) q = v1 - q;
		if (q > VEL_MAX) begin
			r.velocity = 32'h7FFF_FFFF;
			r.status = cvp_pkg::ST_SAT;
		end else if (q < VEL_MIN) begin
			r.velocity = 32'h8000_0000;
			r.status = cvp_pkg::ST_SAT;
		end else begin
			r.velocity = q[31:0];
			r.status = cvp_pkg::ST_OK;
		end
		return r;
	endfunction

	// one register write per cycle; caller lowers wr_en afterwards
	task automatic write_reg(input logic [cvp_pkg::IDX_W-1:0] idx, input logic [31:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			cvp_pkg::REG_V0:  prof_v0 = data;
			cvp_pkg::REG_V1:  prof_v1 = data;
			cvp_pkg::REG_A0:  prof_a0 = data;
			cvp_pkg::REG_A1:  prof_a1 = data;
			cvp_pkg::REG_DUR: prof_dur = data[15:0];
			cvp_pkg::REG_UP:  prof_up = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait for the pipeline to empty, then load a full profile
	task automatic load_profile(input logic [31:0] v0, v1, a0, a1,
		input logic [31:0] dur, input logic [31:0] up);
		start <= 1'b0;
		wait (expected_velocity_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(cvp_pkg::REG_V0, v0);
		write_reg(cvp_pkg::REG_V1, v1);
		write_reg(cvp_pkg::REG_A0, a0);
		write_reg(cvp_pkg::REG_A1, a1);
		write_reg(cvp_pkg::REG_DUR, dur);
		write_reg(cvp_pkg::REG_UP, up);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// send one time beat, with an occasional idle burst in front while idling is on
	task automatic send_tick(input logic [cvp_pkg::TIME_W-1:0] t);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		time_tick <= t;
		do @(posedge clk); while (busy);
		expected_velocity_q.push_back(cubic_velocity(t));
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			3: return 32'(signed'($urandom_range(0, 2097152)) - 1048576);
			default: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF;
			2: return $urandom;
			3: return $urandom_range(1, 4096) | 32'hFFFF_0000;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic logic [cvp_pkg::TIME_W-1:0] pick_tick();
		case ($urandom_range(0, 7))
			0: return 16'hFFFF;
			1: return 16'd0;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, prof_dur + 2));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_tick(16'd0);
		send_tick(16'd1);
		send_tick(16'hFFFF);
	endtask

	task automatic test_zero_duration();
		load_profile(32'h0001_0000, 32'h0005_0000, 32'h100, 32'h200, 32'd0, 32'd1);
		send_tick(16'd0);
		send_tick(16'd77);
		send_tick(16'hFFFF);
	endtask

	task automatic test_smooth_ramp();
		load_profile(32'h0001_0000, 32'h000A_0000, 32'd0, 32'd0, 32'd10, 32'd1);
		for (int i = 0; i <= 11; i++) send_tick(i[cvp_pkg::TIME_W-1:0]);
		send_tick(16'hFFFF);
	endtask

	task automatic test_count_down();
		load_profile(32'hFFFF_0000, 32'h0003_0000, 32'h800, 32'hFFFF_F000, 32'd7, 32'd0);
		send_tick(16'd0);
		send_tick(16'd3);
		send_tick(16'd7);
		send_tick(16'd9);
	endtask

	task automatic test_saturation();
		load_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF, 32'd1);
		send_tick(16'd1);
		send_tick(16'hFFFF);
		load_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'd1, 32'd0);
		send_tick(16'd0);
		send_tick(16'hFFFF);
	endtask

	task automatic test_unused_index();
		start <= 1'b0;
		wait (expected_velocity_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_UNUSED6, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED7, 32'h1234_5678);
		wr_en <= 1'b0;
		send_tick(16'd1);
	endtask

	task automatic test_random_profiles();
		for (int p = 0; p < 40; p++) begin
			load_profile(pick_value(), pick_value(), pick_value(), pick_value(),
				pick_duration(), $urandom);
			if (p >= 34) idling_on = 1'b0;
			repeat ($urandom_range(20, 36)) send_tick(pick_tick());
		end
	endtask

	// result checker
	always @(posedge clk) begin
		velocity_beat_t want;
		if (arst_n && done) begin
			if (expected_velocity_q.size() == 0) begin
				$display("%0t: unexpected velocity beat %h status %0d", $time, velocity, status);
				error_count++;
			end else begin
				want = expected_velocity_q.pop_front();
				if (velocity !== want.velocity) begin
					$display("%0t: velocity expected %h actual %h", $time, want.velocity, velocity);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_duration();
		test_smooth_ramp();
		test_count_down();
		test_saturation();
		test_unused_index();
		test_random_profiles();
		start <= 1'b0;
		wait (expected_velocity_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_velocity_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
